FILE: src/tss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// types and constants shared by the thread state scheduler
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam int MAX_THREADS_DEF = 16;
    localparam int NUM_SEMS_DEF    = 8;

    // request codes
    localparam logic [3:0] FN_CREATE = 4'd0;
    localparam logic [3:0] FN_YIELD  = 4'd1;
    localparam logic [3:0] FN_SUSP   = 4'd2;
    localparam logic [3:0] FN_RESUME = 4'd3;
    localparam logic [3:0] FN_JOIN   = 4'd4;
    localparam logic [3:0] FN_END    = 4'd5;
    localparam logic [3:0] FN_SINIT  = 4'd6;
    localparam logic [3:0] FN_WAIT   = 4'd7;
    localparam logic [3:0] FN_SIGNAL = 4'd8;

    // thread states
    localparam logic [2:0] ST_FREE      = 3'd0;
    localparam logic [2:0] ST_READY     = 3'd1;
    localparam logic [2:0] ST_RUN       = 3'd2;
    localparam logic [2:0] ST_BLOCK     = 3'd3;
    localparam logic [2:0] ST_READY_SUS = 3'd4;
    localparam logic [2:0] ST_BLOCK_SUS = 3'd5;
    localparam logic [2:0] ST_ENDED     = 3'd6;

    typedef struct packed {
        logic [3:0] func;
        logic [3:0] target_tid;
        logic [2:0] sem_index;
        logic [7:0] init_count;
    } t_req;

    typedef struct packed {
        logic       status;
        logic [3:0] new_tid;
        logic [3:0] running_tid;
        logic       running_valid;
        logic       switched;
    } t_rsp;

endpackage

FILE: src/thread_state_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thread_state_scheduler_top
// thread state manager with fifo ready queue and counting semaphores
// ----------------------------------------------------------------------------
// A request is taken when i_start is high and o_busy is low; its response
// word appears on o_rsp for one cycle with o_done high and cannot be stalled.
// While o_busy is high the block may walk its tables: one shared compare unit
// walks the thread table (join check, thread end wake) one entry a cycle and
// the queue shifter moves one entry a cycle, so a request holds the block
// longest for a thread end or a signal followed by a dispatch that shifts a
// long ready queue. The response word shows up in the same cycle that
// o_busy drops.
// Semaphore wait queues sit in a memory of NUM_SEMS * MAX_THREADS entries
// with one read and one write port; no clearing pass is needed.
module thread_state_scheduler_top
    import tss_pkg::*;
#(
    parameter int MAX_THREADS = MAX_THREADS_DEF,
    parameter int NUM_SEMS    = NUM_SEMS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_done,
    output t_rsp o_rsp
);
    localparam int TW = $clog2(MAX_THREADS);
    localparam int CW = TW + 1;
    localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int MW = $clog2(NUM_SEMS * MAX_THREADS);
    localparam logic [CW-1:0] MAXC = CW'(MAX_THREADS);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_EXEC  = 10'b0000000010,
        S_SCAN  = 10'b0000000100,  // join check or thread end wake table scan, one entry a cycle
        S_RQRM  = 10'b0000001000,  // ready queue remove, shift one a cycle
        S_WAKE  = 10'b0000010000,  // wake one thread
        S_SQRD  = 10'b0000100000,  // semaphore head read
        S_SQSH  = 10'b0001000000,  // semaphore queue shift
        S_LEAVE = 10'b0010000000,
        S_DISP  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_st, n_st;

    logic [2:0]    r_ts [MAX_THREADS];
    logic [TW-1:0] r_jt [MAX_THREADS];
    logic          r_jv [MAX_THREADS];
    logic [TW-1:0] r_rq [MAX_THREADS];
    logic [CW-1:0] r_rc;
    logic [TW-1:0] r_run;
    logic [CW-1:0] r_nid;
    logic signed [8:0] r_sc [NUM_SEMS];
    logic [CW-1:0] r_swc [NUM_SEMS];
    logic [TW-1:0] r_mem [NUM_SEMS * MAX_THREADS];
    logic [TW-1:0] r_mrd;

    t_req          r_req;
    logic          r_err, r_wv;
    logic [TW-1:0] r_wt;
    logic [TW-1:0] r_wk;       // thread woken by a signal
    logic [3:0]    r_made;
    logic [CW-1:0] r_i;        // shared scan index
    logic          r_found;
    logic [2:0]    r_lst;      // state given to the leaving thread
    logic          r_mwe;
    logic [MW-1:0] r_mwa;
    logic [TW-1:0] r_mwd;
    logic          r_done;
    t_rsp          r_rsp;

    logic          tid_ok, sem_ok, run_ok, wait_push;
    logic [TW-1:0] tid;
    logic [SW-1:0] sem;
    logic [MW-1:0] base;
    logic [CW-1:0] rc_m1;

    assign tid    = r_req.target_tid[TW-1:0];
    assign sem    = SW'(r_req.sem_index);
    assign tid_ok = 32'(r_req.target_tid) < MAX_THREADS;
    assign sem_ok = 32'(r_req.sem_index) < NUM_SEMS;
    assign run_ok = r_ts[r_run] == ST_RUN;
    assign base   = MW'(32'(sem) * MAX_THREADS);
    assign rc_m1  = r_rc - CW'(1);
    assign wait_push = run_ok && sem_ok && !(r_sc[sem] > 9'sd0) && r_swc[sem] < MAXC;

    // semaphore queue memory
    always_ff @(posedge i_clk) begin
        if (r_mwe) begin
            r_mem[r_mwa] <= r_mwd;
        end
        r_mrd <= r_mem[base + MW'(r_i)];
    end

    // memory write enable and done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mwe  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mwe  <= (r_st == S_EXEC && r_req.func == FN_WAIT && wait_push) ||
                      (r_st == S_SQSH && r_i != CW'(1));
            r_done <= r_st == S_DONE;
        end
    end

    assign o_busy = r_st != S_IDLE;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // sequencer and state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            for (int k = 0; k < MAX_THREADS; k++) begin
                r_ts[k] <= (k == 0) ? ST_RUN : ST_FREE;
                r_jt[k] <= '0;
                r_jv[k] <= 1'b0;
            end
            for (int k = 0; k < NUM_SEMS; k++) begin
                r_sc[k]  <= '0;
                r_swc[k] <= '0;
            end
            r_rc  <= '0;
            r_run <= '0;
            r_nid <= CW'(1);
        end else begin
            r_st <= n_st;
            case (r_st)
                S_IDLE: begin
                    if (i_start) begin
                        r_req  <= i_req;
                        r_err  <= 1'b0;
                        r_made <= '0;
                    end
                end
                S_EXEC: begin
                    r_wv   <= run_ok;
                    r_wt   <= r_run;
                    r_i    <= '0;
                    r_found <= 1'b0;
                    case (r_req.func)
                        FN_CREATE: begin
                            if (r_nid < MAXC) begin
                                r_made <= 4'(r_nid);
                                r_nid <= r_nid + CW'(1);
                                r_ts[r_nid[TW-1:0]] <= ST_READY;
                                r_jv[r_nid[TW-1:0]] <= 1'b0;
                                r_jt[r_nid[TW-1:0]] <= '0;
                                if (r_rc < MAXC) begin
                                    r_rq[r_rc[TW-1:0]] <= r_nid[TW-1:0];
                                    r_rc <= r_rc + CW'(1);
                                end
                            end else r_err <= 1'b1;
                        end
                        FN_YIELD: begin
                            if (!run_ok) r_err <= 1'b1;
                            r_lst <= ST_READY;
                        end
                        FN_SUSP: begin
                            if (!tid_ok) r_err <= 1'b1;
                            else if (r_ts[tid] == ST_BLOCK) r_ts[tid] <= ST_BLOCK_SUS;
                            else if (r_ts[tid] == ST_READY) r_ts[tid] <= ST_READY_SUS;
                            else r_err <= 1'b1;
                        end
                        FN_RESUME: begin
                            if (!tid_ok) r_err <= 1'b1;
                            else if (r_ts[tid] == ST_BLOCK_SUS) r_ts[tid] <= ST_BLOCK;
                            else if (r_ts[tid] == ST_READY_SUS) begin
                                r_ts[tid] <= ST_READY;
                                if (r_rc < MAXC) begin
                                    r_rq[r_rc[TW-1:0]] <= tid;
                                    r_rc <= r_rc + CW'(1);
                                end
                            end else r_err <= 1'b1;
                        end
                        FN_JOIN: begin
                            r_lst <= ST_BLOCK;
                            if (!run_ok || !tid_ok) r_err <= 1'b1;
                            else if (!(r_ts[tid] == ST_READY || r_ts[tid] == ST_BLOCK ||
                                       r_ts[tid] == ST_READY_SUS ||
                                       r_ts[tid] == ST_BLOCK_SUS)) r_err <= 1'b1;
                        end
                        FN_END: begin
                            r_lst <= ST_ENDED;
                            if (!run_ok) r_err <= 1'b1;
                        end
                        FN_SINIT: begin
                            if (!sem_ok || r_swc[sem] != '0) r_err <= 1'b1;
                            else r_sc[sem] <= $signed({1'b0, r_req.init_count});
                        end
                        FN_WAIT: begin
                            r_lst <= ST_BLOCK;
                            if (!run_ok || !sem_ok) r_err <= 1'b1;
                            else if (r_sc[sem] > 9'sd0) r_sc[sem] <= r_sc[sem] - 9'sd1;
                            else if (r_swc[sem] >= MAXC) r_err <= 1'b1;
                            else begin
                                if (r_sc[sem] > -9'sd256) r_sc[sem] <= r_sc[sem] - 9'sd1;
                                r_mwa <= base + MW'(r_swc[sem]);
                                r_mwd <= r_run;
                                r_swc[sem] <= r_swc[sem] + CW'(1);
                                r_jv[r_run] <= 1'b0;
                            end
                        end
                        FN_SIGNAL: begin
                            if (!sem_ok) r_err <= 1'b1;
                            else if (r_sc[sem] < 9'sd255) r_sc[sem] <= r_sc[sem] + 9'sd1;
                        end
                        default: r_err <= 1'b1;
                    endcase
                end
                S_SCAN: begin
                    // join check or thread end wake, one entry a cycle
                    if (r_req.func == FN_JOIN) begin
                        if (r_jv[r_i[TW-1:0]] && r_jt[r_i[TW-1:0]] == tid) r_err <= 1'b1;
                    end else if (r_jv[r_i[TW-1:0]] && r_jt[r_i[TW-1:0]] == r_wt) begin
                        r_jv[r_i[TW-1:0]] <= 1'b0;
                        r_jt[r_i[TW-1:0]] <= '0;
                        if (r_ts[r_i[TW-1:0]] == ST_BLOCK_SUS)
                            r_ts[r_i[TW-1:0]] <= ST_READY_SUS;
                        else if (r_ts[r_i[TW-1:0]] == ST_BLOCK) begin
                            r_ts[r_i[TW-1:0]] <= ST_READY;
                            if (r_rc < MAXC) begin
                                r_rq[r_rc[TW-1:0]] <= r_i[TW-1:0];
                                r_rc <= r_rc + CW'(1);
                            end
                        end
                    end
                    r_i <= (n_st == S_SCAN) ? r_i + CW'(1) : '0;
                    if (r_req.func == FN_JOIN && n_st == S_LEAVE) begin
                        r_jt[r_wt] <= tid;
                        r_jv[r_wt] <= 1'b1;
                    end
                end
                S_RQRM: begin
                    // find the target, then shift later entries down
                    if (r_i < r_rc) begin
                        if (r_found) r_rq[r_i[TW-1:0] - TW'(1)] <= r_rq[r_i[TW-1:0]];
                        else if (r_rq[r_i[TW-1:0]] == tid) r_found <= 1'b1;
                        r_i <= r_i + CW'(1);
                    end else begin
                        if (r_found) r_rc <= rc_m1;
                        r_i <= '0;
                    end
                end
                S_SQRD: begin
                    r_i <= CW'(1);
                end
                S_SQSH: begin
                    // latch the head first, then copy each later entry down by one
                    if (r_i == CW'(1)) r_wk <= r_mrd;
                    else begin
                        r_mwa <= base + MW'(r_i) - MW'(2);
                        r_mwd <= r_mrd;
                    end
                    r_i <= r_i + CW'(1);
                    if (n_st == S_WAKE) r_swc[sem] <= r_swc[sem] - CW'(1);
                end
                S_WAKE: begin
                    if (r_ts[r_wk] == ST_BLOCK_SUS) r_ts[r_wk] <= ST_READY_SUS;
                    else if (r_ts[r_wk] == ST_BLOCK) begin
                        r_ts[r_wk] <= ST_READY;
                        if (r_rc < MAXC) begin
                            r_rq[r_rc[TW-1:0]] <= r_wk;
                            r_rc <= r_rc + CW'(1);
                        end
                    end
                    r_i <= '0;
                end
                S_LEAVE: begin
                    r_ts[r_run] <= r_lst;
                    if (r_lst == ST_READY && r_rc < MAXC) begin
                        r_rq[r_rc[TW-1:0]] <= r_run;
                        r_rc <= r_rc + CW'(1);
                    end
                    r_i <= '0;
                end
                S_DISP: begin
                    // dispatch walks the queue shift one entry a cycle
                    if (r_i == '0) begin
                        if (!run_ok && r_rc != '0) begin
                            r_run <= r_rq[0];
                            r_ts[r_rq[0]] <= ST_RUN;
                            r_i <= CW'(1);
                        end
                    end else if (r_i < r_rc) begin
                        r_rq[r_i[TW-1:0] - TW'(1)] <= r_rq[r_i[TW-1:0]];
                        r_i <= r_i + CW'(1);
                    end else begin
                        r_rc <= rc_m1;
                    end
                end
                S_DONE: begin
                    r_rsp.status        <= r_err;
                    r_rsp.new_tid       <= (r_req.func == FN_CREATE && !r_err) ? r_made : '0;
                    r_rsp.running_tid   <= run_ok ? 4'(r_run) : '0;
                    r_rsp.running_valid <= run_ok;
                    r_rsp.switched      <= (run_ok != r_wv) ||
                                           (run_ok && r_wv && r_run != r_wt);
                end
                default: ;
            endcase
        end
    end

    // next step of the sequencer
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (i_start) n_st = S_EXEC;
            S_EXEC: begin
                n_st = S_DISP;
                case (r_req.func)
                    FN_YIELD: if (run_ok) n_st = S_LEAVE;
                    FN_SUSP:  if (tid_ok && r_ts[tid] == ST_READY) n_st = S_RQRM;
                    FN_JOIN, FN_END: begin
                        if (run_ok && tid_ok && (r_req.func == FN_END ||
                            r_ts[tid] == ST_READY || r_ts[tid] == ST_BLOCK ||
                            r_ts[tid] == ST_READY_SUS || r_ts[tid] == ST_BLOCK_SUS))
                            n_st = S_SCAN;
                        else if (r_req.func == FN_END && run_ok) n_st = S_SCAN;
                    end
                    FN_WAIT: if (wait_push) n_st = S_LEAVE;
                    FN_SIGNAL: if (sem_ok && r_swc[sem] != '0) n_st = S_SQRD;
                    default: n_st = S_DISP;
                endcase
            end
            S_SCAN: begin
                if (r_i == MAXC - CW'(1)) begin
                    if (r_req.func == FN_JOIN &&
                        (r_err || (r_jv[r_i[TW-1:0]] && r_jt[r_i[TW-1:0]] == tid)))
                        n_st = S_DISP;
                    else n_st = S_LEAVE;
                end
            end
            S_RQRM:  if (r_i >= r_rc) n_st = S_DISP;
            S_SQRD:  n_st = S_SQSH;
            S_SQSH:  if (r_i >= r_swc[sem]) n_st = S_WAKE;
            S_WAKE:  n_st = S_DISP;
            S_LEAVE: n_st = S_DISP;
            S_DISP: begin
                if (r_i == '0) begin
                    if (run_ok || r_rc == '0) n_st = S_DONE;
                end else if (r_i >= r_rc) n_st = S_DONE;
            end
            S_DONE:  n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the thread state scheduler: requests go in through
// the start/busy handshake, a behavioral model of thread states, ready fifo
// and semaphores predicts each response word, which is compared on o_done
// ----------------------------------------------------------------------------
module tb
    import tss_pkg::*;
();

    localparam int STALL_LIMIT = 20000;
    localparam logic [3:0] FN_BAD = 4'd15;

    // behavioral scheduler model and response checker
    class sched_scoreboard;
        logic [2:0] thr_state [16];
        logic [3:0] join_tgt [16];
        bit         join_on [16];
        logic [3:0] rdy_q [$];
        logic [3:0] run_tid;
        int         next_tid;
        int         sem_cnt [8];
        logic [3:0] sem_q [8][$];
        t_rsp       pending [$];
        int         mismatches;

        function new();
            for (int i = 0; i < 16; i++) begin
                thr_state[i] = ST_FREE;
                join_tgt[i] = 0;
                join_on[i] = 0;
            end
            thr_state[0] = ST_RUN;
            run_tid = 0;
            next_tid = 1;
            for (int s = 0; s < 8; s++) sem_cnt[s] = 0;
            mismatches = 0;
        endfunction

        function bit is_running();
            return thr_state[run_tid] == ST_RUN;
        endfunction

        function void push_ready(logic [3:0] t);
            if (rdy_q.size() < 16) rdy_q.push_back(t);
        endfunction

        function void drop_ready(logic [3:0] t);
            foreach (rdy_q[i]) begin
                if (rdy_q[i] == t) begin
                    rdy_q.delete(i);
                    return;
                end
            end
        endfunction

        function void wake(logic [3:0] t);
            if (thr_state[t] == ST_BLOCK_SUS) begin
                thr_state[t] = ST_READY_SUS;
            end else if (thr_state[t] == ST_BLOCK) begin
                thr_state[t] = ST_READY;
                push_ready(t);
            end
        endfunction

        function void dispatch();
            if (is_running() || rdy_q.size() == 0) return;
            run_tid = rdy_q.pop_front();
            thr_state[run_tid] = ST_RUN;
        endfunction

        function void leave_running(logic [2:0] st);
            thr_state[run_tid] = st;
            if (st == ST_READY) push_ready(run_tid);
            dispatch();
        endfunction

        // note an accepted request and queue the response it should give
        function void note_request(t_req r);
            bit         was_on;
            logic [3:0] was_tid;
            bit         err;
            logic [3:0] made;
            logic [3:0] t;
            int         s;
            t_rsp       e;
            was_on = is_running();
            was_tid = run_tid;
            err = 0;
            made = 0;
            t = r.target_tid;
            s = int'(r.sem_index);
            case (r.func)
                FN_CREATE: begin
                    if (next_tid < 16) begin
                        made = next_tid[3:0];
                        next_tid++;
                        thr_state[made] = ST_READY;
                        join_on[made] = 0;
                        join_tgt[made] = 0;
                        push_ready(made);
                    end else err = 1;
                end
                FN_YIELD: begin
                    if (was_on) leave_running(ST_READY); else err = 1;
                end
                FN_SUSP: begin
                    if (thr_state[t] == ST_BLOCK) thr_state[t] = ST_BLOCK_SUS;
                    else if (thr_state[t] == ST_READY) begin
                        drop_ready(t);
                        thr_state[t] = ST_READY_SUS;
                    end else err = 1;
                end
                FN_RESUME: begin
                    if (thr_state[t] == ST_BLOCK_SUS) thr_state[t] = ST_BLOCK;
                    else if (thr_state[t] == ST_READY_SUS) begin
                        thr_state[t] = ST_READY;
                        push_ready(t);
                    end else err = 1;
                end
                FN_JOIN: begin
                    if (!was_on) err = 1;
                    else if (!(thr_state[t] inside {ST_READY, ST_BLOCK, ST_READY_SUS,
                                                    ST_BLOCK_SUS})) err = 1;
                    else begin
                        for (int i = 0; i < 16; i++)
                            if (join_on[i] && join_tgt[i] == t) err = 1;
                        if (!err) begin
                            join_tgt[run_tid] = t;
                            join_on[run_tid] = 1;
                            leave_running(ST_BLOCK);
                        end
                    end
                end
                FN_END: begin
                    if (!was_on) err = 1;
                    else begin
                        for (int i = 0; i < 16; i++) begin
                            if (join_on[i] && join_tgt[i] == run_tid) begin
                                join_on[i] = 0;
                                join_tgt[i] = 0;
                                wake(i[3:0]);
                            end
                        end
                        leave_running(ST_ENDED);
                    end
                end
                FN_SINIT: begin
                    if (sem_q[s].size() != 0) err = 1;
                    else sem_cnt[s] = int'(r.init_count);
                end
                FN_WAIT: begin
                    if (!was_on) err = 1;
                    else if (sem_cnt[s] > 0) sem_cnt[s]--;
                    else if (sem_q[s].size() >= 16) err = 1;
                    else begin
                        if (sem_cnt[s] > -256) sem_cnt[s]--;
                        sem_q[s].push_back(run_tid);
                        join_on[run_tid] = 0;
                        leave_running(ST_BLOCK);
                    end
                end
                FN_SIGNAL: begin
                    if (sem_cnt[s] < 255) sem_cnt[s]++;
                    if (sem_q[s].size() > 0) wake(sem_q[s].pop_front());
                end
                default: err = 1;
            endcase
            dispatch();
            e.status = err;
            e.new_tid = (r.func == FN_CREATE && !err) ? made : 4'd0;
            e.running_valid = is_running();
            e.running_tid = e.running_valid ? run_tid : 4'd0;
            e.switched = (e.running_valid != was_on) ||
                         (e.running_valid && was_on && run_tid != was_tid);
            pending.push_back(e);
        endfunction

        // compare one response word with the oldest expectation
        function void check_response(t_rsp got);
            t_rsp e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected response %h", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st=%0d new=%0d run=%0d v=%0d sw=%0d",
                             e.status, e.new_tid, e.running_tid, e.running_valid,
                             e.switched,
                             " got st=%0d new=%0d run=%0d v=%0d sw=%0d",
                             got.status, got.new_tid, got.running_tid,
                             got.running_valid, got.switched);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_done;
    t_rsp o_rsp;

    sched_scoreboard sb;
    int idle_pct;
    int quiet_cycles;
    int items_sent;

    thread_state_scheduler_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_req  (i_req),
        .o_busy (o_busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // response capture and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) sb.check_response(o_rsp);
            if (o_done || (i_start && !o_busy)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // present one request word and hold it until it is taken
    task automatic send_word(t_req r);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 0;
            @(posedge i_clk);
        end
        i_start <= 1;
        i_req <= r;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        sb.note_request(r);
        items_sent++;
    endtask

    task automatic send_op(logic [3:0] f, logic [3:0] t, logic [2:0] s, logic [7:0] c);
        t_req r;
        r.func = f;
        r.target_tid = t;
        r.sem_index = s;
        r.init_count = c;
        send_word(r);
    endtask

    // random request biased toward legal, state-driving operations
    task automatic send_random();
        int   p;
        t_req r;
        logic [3:0] t;
        p = $urandom_range(99);
        t = (sb.next_tid > 1) ? 4'($urandom_range(sb.next_tid - 1)) : 4'd0;
        r.target_tid = ($urandom_range(9) == 0) ? 4'($urandom) : t;
        r.sem_index = ($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(1));
        r.init_count = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(2));
        if (p < 6) r.func = FN_CREATE;
        else if (p < 22) r.func = FN_YIELD;
        else if (p < 30) r.func = FN_SUSP;
        else if (p < 40) r.func = FN_RESUME;
        else if (p < 48) r.func = FN_JOIN;
        else if (p < 52) r.func = FN_END;
        else if (p < 58) r.func = FN_SINIT;
        else if (p < 75) r.func = FN_WAIT;
        else if (p < 96) r.func = FN_SIGNAL;
        else r.func = 4'($urandom_range(15, 9));
        send_word(r);
    endtask

    initial begin
        sb = new();
        i_rst_n = 0;
        i_start = 0;
        i_req = '0;
        quiet_cycles = 0;
        items_sent = 0;
        idle_pct = 8;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: errors, extremes, suspend of a waiter, saturation
        send_op(FN_BAD, 4'd15, 3'd7, 8'hff);
        send_op(FN_SIGNAL, 4'd0, 3'd7, 8'd0);
        send_op(FN_SINIT, 4'd0, 3'd7, 8'hff);
        send_op(FN_SIGNAL, 4'd0, 3'd7, 8'd0);
        send_op(FN_CREATE, 4'd0, 3'd0, 8'd0);
        send_op(FN_CREATE, 4'd0, 3'd0, 8'd0);
        send_op(FN_JOIN, 4'd1, 3'd0, 8'd0);
        send_op(FN_JOIN, 4'd1, 3'd0, 8'd0);
        send_op(FN_SUSP, 4'd0, 3'd0, 8'd0);
        send_op(FN_WAIT, 4'd0, 3'd2, 8'd0);
        send_op(FN_SUSP, 4'd1, 3'd0, 8'd0);
        send_op(FN_SIGNAL, 4'd0, 3'd2, 8'd0);
        send_op(FN_RESUME, 4'd1, 3'd0, 8'd0);
        send_op(FN_SINIT, 4'd0, 3'd2, 8'd3);
        send_op(FN_RESUME, 4'd15, 3'd0, 8'd0);
        send_op(FN_YIELD, 4'd0, 3'd0, 8'd0);
        send_op(FN_END, 4'd0, 3'd0, 8'd0);
        send_op(FN_END, 4'd0, 3'd0, 8'd0);
        send_op(FN_END, 4'd0, 3'd0, 8'd0);
        send_op(FN_YIELD, 4'd0, 3'd0, 8'd0);
        send_op(FN_WAIT, 4'd0, 3'd0, 8'd0);

        // random phases; restart is impossible, so ids run out and ops stay legal-ish
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 8 : (ph == 1) ? 48 : 0;
            for (int n = 0; n < 250; n++) send_random();
        end
        i_start <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule

FILE: sim.f
src/tss_pkg.sv
src/thread_state_scheduler_top.sv
test/tb.sv
